@@ design/skhs_pkg.sv @@
// skhs_pkg: shared constants, operation and status codes, and the control
// structs between the hash unit and the sequencer of string_key_hash_set.
// No dependencies.
package skhs_pkg;

  localparam int DefBuckets   = 64;
  localparam int DefWays      = 1;
  localparam int DefMaxKeyLen = 16;

  localparam logic [63:0] HashSeed  = 64'd5381;
  localparam int unsigned HashShift = 5;

  // operation codes; find and the unused code both fall to the default arm
  localparam logic [1:0] ModeInsert = 2'd0;
  localparam logic [1:0] ModeRemove = 2'd2;

  localparam logic [2:0] StAdded     = 3'd0;
  localparam logic [2:0] StDuplicate = 3'd1;
  localparam logic [2:0] StFull      = 3'd2;
  localparam logic [2:0] StFound     = 3'd3;
  localparam logic [2:0] StNotFound  = 3'd4;
  localparam logic [2:0] StRemoved   = 3'd5;
  localparam logic [2:0] StTooLong   = 3'd6;

  typedef struct packed {
    logic accept;
    logic last;
    logic clear;
  } hash_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } hash_sts_t;

endpackage

@@ design/string_key_hash_set.sv @@
// string_key_hash_set: top level, sequencer, key buffer, key store and
// slot-length table. Uses skhs_pkg, skhs_hash and skhs_ram.
//
// A key arrives one byte per input transaction; last_i marks its final byte and
// mode_i on that byte selects insert (0), remove (2) or find (any other code).
// Non-final bytes are taken one per cycle. After the final byte the block
// stalls its input while it works and then produces one result transaction:
// status, bucket index and slot.
// After the final byte the hash unit reduces the hash to a bucket index (one
// hash byte reduced a cycle unless BUCKETS is a power of two). Then the bucket's
// slot lengths are read, each way is visited, and each occupied way of equal
// length is compared byte by byte until a hit (one key-store read port); then a
// decision step, a byte-by-byte copy of a newly inserted key, and the load of
// the output register. A too-long key goes straight to the output.
// The result sits in an output register, so the input opens again once it is
// loaded; while a result is stalled, the next operation waits in its load
// step with the input stalled.
// After reset the slot-length table is swept clear, one bucket per cycle, with
// the input stalled.
module string_key_hash_set import skhs_pkg::*; #(
  parameter int BUCKETS = DefBuckets,
  parameter int WAYS = DefWays,
  parameter int MAX_KEY_LEN = DefMaxKeyLen
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] key_byte_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_o,
  output logic [5:0] bucket_o,
  output logic [2:0] slot_o
);

  localparam int BW    = $clog2(BUCKETS);
  localparam int CW    = $clog2(MAX_KEY_LEN + 2);
  localparam int LW    = $clog2(MAX_KEY_LEN + 1);
  localparam int KAW   = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int KDEP  = BUCKETS * WAYS * MAX_KEY_LEN;
  localparam int AW    = $clog2(KDEP);
  localparam int RowW  = WAYS * LW;
  localparam int RowBytes = WAYS * MAX_KEY_LEN;

  localparam logic [3:0] FsmClear  = 4'd0;
  localparam logic [3:0] FsmIdle   = 4'd1;
  localparam logic [3:0] FsmHash   = 4'd2;
  localparam logic [3:0] FsmRow    = 4'd3;
  localparam logic [3:0] FsmWay    = 4'd4;
  localparam logic [3:0] FsmCmpRd  = 4'd5;
  localparam logic [3:0] FsmCmpCk  = 4'd6;
  localparam logic [3:0] FsmDecide = 4'd7;
  localparam logic [3:0] FsmCpRd   = 4'd8;
  localparam logic [3:0] FsmCpWr   = 4'd9;
  localparam logic [3:0] FsmDone   = 4'd10;

  logic [3:0]    state_q, state_d;
  logic [1:0]    mode_q, mode_d;
  logic [BW-1:0] clr_q, clr_d;
  logic [RowW-1:0] row_q, row_d, row_new;
  logic [WW-1:0] w_q, w_d, hit_way_q, hit_way_d, free_way_q, free_way_d, sel_way;
  logic          hit_q, hit_d, free_q, free_d;
  logic [AW-1:0] way_base_q, way_base_d, free_base_q, free_base_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [2:0]    status_q, status_d, slot_q, slot_d;
  logic          out_valid_q, out_valid_d;
  logic [2:0]    out_status_q, out_status_d, out_slot_q, out_slot_d;
  logic [5:0]    out_bucket_q, out_bucket_d;

  logic          accept, load, adv, last_idx;
  logic [LW-1:0] slen;
  hash_ctrl_t    hash_ctrl;
  hash_sts_t     hash_sts;
  logic [BW-1:0] bucket;
  logic [CW-1:0] key_len;

  logic          kb_we, kr_we, lr_we;
  logic [7:0]    kb_rdata, kr_rdata;
  logic [RowW-1:0] lr_rdata, lr_wdata;
  logic [BW-1:0] lr_waddr;

  assign accept   = in_valid_i && !in_stall_o;
  assign load     = !(out_valid_q && out_stall_i);
  assign last_idx = (idx_q == key_len - 1'b1);
  assign slen     = row_q[w_q*LW +: LW];

  assign hash_ctrl.accept = accept;
  assign hash_ctrl.last   = last_i;
  assign hash_ctrl.clear  = (state_q == FsmDone) && load;

  skhs_hash #(
    .BUCKETS     (BUCKETS),
    .MAX_KEY_LEN (MAX_KEY_LEN)
  ) u_hash (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (hash_ctrl),
    .key_byte_i (key_byte_i),
    .sts_o      (hash_sts),
    .bucket_o   (bucket),
    .key_len_o  (key_len)
  );

  // key buffer: written while bytes stream in, read during compare and copy
  assign kb_we = accept && (key_len < CW'(MAX_KEY_LEN));

  skhs_ram #(.WIDTH(8), .DEPTH(MAX_KEY_LEN)) u_key_buf (
    .clk_i   (clk_i),
    .we_i    (kb_we),
    .waddr_i (key_len[KAW-1:0]),
    .wdata_i (key_byte_i),
    .raddr_i (idx_q[KAW-1:0]),
    .rdata_o (kb_rdata)
  );

  // stored key bytes, MAX_KEY_LEN bytes per slot
  assign kr_we = (state_q == FsmCpWr);

  skhs_ram #(.WIDTH(8), .DEPTH(KDEP)) u_key_store (
    .clk_i   (clk_i),
    .we_i    (kr_we),
    .waddr_i (free_base_q + AW'(idx_q)),
    .wdata_i (kb_rdata),
    .raddr_i (way_base_q + AW'(idx_q)),
    .rdata_o (kr_rdata)
  );

  // slot lengths, one row of WAYS fields per bucket; zero marks an empty slot
  assign sel_way = (state_q == FsmDecide) ? hit_way_q : free_way_q;

  always_comb begin
    row_new = row_q;
    row_new[sel_way*LW +: LW] = (state_q == FsmDecide) ? '0 : LW'(key_len);
  end

  assign lr_we = (state_q == FsmClear)
              || ((state_q == FsmDecide) && (mode_q == ModeRemove) && hit_q)
              || ((state_q == FsmCpWr) && last_idx);
  assign lr_waddr = (state_q == FsmClear) ? clr_q : bucket;
  assign lr_wdata = (state_q == FsmClear) ? '0 : row_new;

  skhs_ram #(.WIDTH(RowW), .DEPTH(BUCKETS)) u_len_tab (
    .clk_i   (clk_i),
    .we_i    (lr_we),
    .waddr_i (lr_waddr),
    .wdata_i (lr_wdata),
    .raddr_i (bucket),
    .rdata_o (lr_rdata)
  );

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    clr_d        = clr_q;
    row_d        = row_q;
    w_d          = w_q;
    hit_d        = hit_q;
    hit_way_d    = hit_way_q;
    free_d       = free_q;
    free_way_d   = free_way_q;
    way_base_d   = way_base_q;
    free_base_d  = free_base_q;
    idx_d        = idx_q;
    status_d     = status_q;
    slot_d       = slot_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_bucket_d = out_bucket_q;
    out_slot_d   = out_slot_q;
    adv          = 1'b0;

    case (state_q)
      FsmClear: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == BW'(BUCKETS - 1)) begin
          state_d = FsmIdle;
        end
      end
      FsmIdle: begin
        if (accept && last_i) begin
          mode_d  = mode_i;
          state_d = FsmHash;
        end
      end
      FsmHash: begin
        if (hash_sts.done) begin
          w_d        = '0;
          hit_d      = 1'b0;
          free_d     = 1'b0;
          hit_way_d  = '0;
          free_way_d = '0;
          way_base_d = AW'(bucket * RowBytes);
          if (key_len > CW'(MAX_KEY_LEN)) begin
            status_d = StTooLong;
            slot_d   = '0;
            state_d  = FsmDone;
          end else begin
            state_d = FsmRow;
          end
        end
      end
      FsmRow: begin
        row_d   = lr_rdata;
        state_d = FsmWay;
      end
      FsmWay: begin
        if (slen == '0) begin
          if (!free_q) begin
            free_d      = 1'b1;
            free_way_d  = w_q;
            free_base_d = way_base_q;
          end
          adv = 1'b1;
        end else if (!hit_q && (CW'(slen) == key_len)) begin
          idx_d   = '0;
          state_d = FsmCmpRd;
        end else begin
          adv = 1'b1;
        end
      end
      FsmCmpRd: begin
        state_d = FsmCmpCk;
      end
      FsmCmpCk: begin
        if (kb_rdata != kr_rdata) begin
          adv = 1'b1;
        end else if (last_idx) begin
          hit_d     = 1'b1;
          hit_way_d = w_q;
          adv       = 1'b1;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = FsmCmpRd;
        end
      end
      FsmDecide: begin
        state_d = FsmDone;
        case (mode_q)
          ModeInsert: begin
            if (hit_q) begin
              status_d = StDuplicate;
              slot_d   = 3'(hit_way_q);
            end else if (free_q) begin
              idx_d   = '0;
              state_d = FsmCpRd;
            end else begin
              status_d = StFull;
              slot_d   = '0;
            end
          end
          ModeRemove: begin
            status_d = hit_q ? StRemoved : StNotFound;
            slot_d   = hit_q ? 3'(hit_way_q) : 3'd0;
          end
          default: begin
            status_d = hit_q ? StFound : StNotFound;
            slot_d   = hit_q ? 3'(hit_way_q) : 3'd0;
          end
        endcase
      end
      FsmCpRd: begin
        state_d = FsmCpWr;
      end
      FsmCpWr: begin
        if (last_idx) begin
          status_d = StAdded;
          slot_d   = 3'(free_way_q);
          state_d  = FsmDone;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = FsmCpRd;
        end
      end
      FsmDone: begin
        if (load) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_bucket_d = 6'(bucket);
          out_slot_d   = slot_q;
          state_d      = FsmIdle;
        end
      end
      default: begin
        state_d = FsmIdle;
      end
    endcase

    if (adv) begin
      if (w_q == WW'(WAYS - 1)) begin
        state_d = FsmDecide;
      end else begin
        w_d        = w_q + 1'b1;
        way_base_d = way_base_q + AW'(MAX_KEY_LEN);
        state_d    = FsmWay;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FsmClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    row_q        <= row_d;
    w_q          <= w_d;
    hit_q        <= hit_d;
    hit_way_q    <= hit_way_d;
    free_q       <= free_d;
    free_way_q   <= free_way_d;
    way_base_q   <= way_base_d;
    free_base_q  <= free_base_d;
    idx_q        <= idx_d;
    status_q     <= status_d;
    slot_q       <= slot_d;
    out_status_q <= out_status_d;
    out_bucket_q <= out_bucket_d;
    out_slot_q   <= out_slot_d;
  end

  assign in_stall_o  = (state_q != FsmIdle);
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign bucket_o    = out_bucket_q;
  assign slot_o      = out_slot_q;

  a_last_starts_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_i |=> state_q == FsmHash)
    else $error("final byte did not start an operation");

  a_mod_only_in_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_sts.busy |-> state_q == FsmHash)
    else $error("bucket reduction running outside the hash wait");

  a_miss_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StFull || status_o == StNotFound ||
                    status_o == StTooLong) |-> slot_o == 3'd0)
    else $error("nonzero slot reported on a miss");

  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FsmDone && !load |=> state_q == FsmDone && in_stall_o)
    else $error("sequencer left done state while output was blocked");

endmodule

@@ design/skhs_ram.sv @@
// skhs_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module skhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/skhs_hash.sv @@
// skhs_hash: djb33-xor running hash, key length count and a byte-serial
// modulo unit that reduces the 64-bit hash to a bucket index. Uses skhs_pkg.
module skhs_hash import skhs_pkg::*; #(
  parameter int BUCKETS = DefBuckets,
  parameter int MAX_KEY_LEN = DefMaxKeyLen,
  localparam int BW = $clog2(BUCKETS),
  localparam int CW = $clog2(MAX_KEY_LEN + 2)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hash_ctrl_t    ctrl_i,
  input  logic [7:0]    key_byte_i,
  output hash_sts_t     sts_o,
  output logic [BW-1:0] bucket_o,
  output logic [CW-1:0] key_len_o
);

  localparam int TW = BW + 8;
  localparam bit Pow2 = ((BUCKETS & (BUCKETS - 1)) == 0);
  // 2^32 / BUCKETS rounded up; the quotient of a dividend below 256 * BUCKETS
  // comes out exact for BUCKETS below 4096
  localparam logic [31:0] Recip = 32'((64'd1 << 32) / BUCKETS + 1);

  logic [63:0]    hash_q, hash_d, hash_step;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           busy_q, busy_d, done_q, done_d;
  logic [2:0]     step_q, step_d;
  logic [BW-1:0]  rem_q, rem_d, bucket_q, bucket_d;
  logic [TW-1:0]  dvd, rem_next;
  logic [TW+31:0] prod;
  logic [7:0]     quo;

  assign hash_step = ((hash_q << HashShift) + hash_q) ^ {56'd0, key_byte_i};

  // one reduction step a cycle, top hash byte first:
  // rem = (rem * 256 + byte) mod BUCKETS through the reciprocal
  assign dvd      = {rem_q, hash_q[63:56]};
  assign prod     = (TW+32)'(dvd) * (TW+32)'(Recip);
  assign quo      = prod[39:32];
  assign rem_next = dvd - TW'(quo * BUCKETS);

  always_comb begin
    hash_d   = hash_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    done_d   = done_q;
    step_d   = step_q;
    rem_d    = rem_q;
    bucket_d = bucket_q;
    if (ctrl_i.clear) begin
      hash_d = HashSeed;
      cnt_d  = '0;
      done_d = 1'b0;
    end else if (ctrl_i.accept) begin
      hash_d = hash_step;
      if (cnt_q <= CW'(MAX_KEY_LEN)) begin
        cnt_d = cnt_q + 1'b1;
      end
      if (ctrl_i.last) begin
        if (Pow2) begin
          bucket_d = hash_step[BW-1:0];
          done_d   = 1'b1;
        end else begin
          busy_d = 1'b1;
          step_d = '0;
          rem_d  = '0;
        end
      end
    end else if (busy_q) begin
      hash_d = {hash_q[55:0], 8'd0};
      rem_d  = rem_next[BW-1:0];
      step_d = step_q + 1'b1;
      if (step_q == 3'd7) begin
        busy_d   = 1'b0;
        done_d   = 1'b1;
        bucket_d = rem_next[BW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= HashSeed;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      hash_q <= hash_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    bucket_q <= bucket_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign bucket_o   = bucket_q;
  assign key_len_o  = cnt_q;

endmodule

@@ tb/string_key_hash_set_checker.sv @@
// string_key_hash_set_checker: watches both channels of string_key_hash_set,
// predicts each outcome from its own copy of the hash set, and compares.
// Depends on skhs_pkg for the hash constants and the status and operation codes.
module string_key_hash_set_checker import skhs_pkg::*; #(
  parameter int BUCKETS = DefBuckets,
  parameter int WAYS = DefWays,
  parameter int MAX_KEY_LEN = DefMaxKeyLen
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [1:0] mode_i,
  input  logic [7:0] key_byte_i,
  input  logic       last_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [2:0] status_i,
  input  logic [5:0] bucket_i,
  input  logic [2:0] slot_i,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] bucket;
    logic [2:0] slot;
  } outcome_t;

  // key being assembled
  logic [63:0]  key_hash;
  logic [7:0]   key_bytes[MAX_KEY_LEN];
  int unsigned  key_len;
  // stored keys, one entry per slot
  logic [7:0]   table_bytes[BUCKETS*WAYS*MAX_KEY_LEN];
  int unsigned  table_len[BUCKETS*WAYS];

  outcome_t     outcomes_due[$];
  int           mismatches;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  function automatic bit key_matches(input int unsigned sidx);
    if (table_len[sidx] != key_len) return 1'b0;
    for (int unsigned i = 0; i < key_len; i++) begin
      if (table_bytes[sidx*MAX_KEY_LEN + i] != key_bytes[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic absorb_byte(input logic [1:0] mode, input logic [7:0] kb, input logic kl);
    outcome_t    res;
    int unsigned idx;
    int unsigned sidx;
    int unsigned hit_way;
    int unsigned free_way;
    bit          hit;
    bit          have_free;

    key_hash = ((key_hash << HashShift) + key_hash) ^ {56'd0, kb};
    if (key_len < MAX_KEY_LEN) key_bytes[key_len] = kb;
    if (key_len <= MAX_KEY_LEN) key_len++;
    if (!kl) return;

    idx = int'(key_hash % 64'(BUCKETS));
    res.bucket = idx[5:0];
    res.slot = '0;
    hit = 1'b0;
    have_free = 1'b0;
    hit_way = 0;
    free_way = 0;
    if (key_len > MAX_KEY_LEN) begin
      res.status = StTooLong;
    end else begin
      for (int unsigned w = 0; w < WAYS; w++) begin
        sidx = idx*WAYS + w;
        if (table_len[sidx] == 0) begin
          if (!have_free) begin
            have_free = 1'b1;
            free_way = w;
          end
        end else if (!hit && key_matches(sidx)) begin
          hit = 1'b1;
          hit_way = w;
        end
      end
      case (mode)
        ModeInsert: begin
          if (hit) begin
            res.status = StDuplicate;
            res.slot = 3'(hit_way);
          end else if (have_free) begin
            sidx = idx*WAYS + free_way;
            for (int unsigned i = 0; i < key_len; i++) begin
              table_bytes[sidx*MAX_KEY_LEN + i] = key_bytes[i];
            end
            table_len[sidx] = key_len;
            res.status = StAdded;
            res.slot = 3'(free_way);
          end else begin
            res.status = StFull;
          end
        end
        ModeRemove: begin
          if (hit) begin
            table_len[idx*WAYS + hit_way] = 0;
            res.status = StRemoved;
            res.slot = 3'(hit_way);
          end else begin
            res.status = StNotFound;
          end
        end
        default: begin
          // find, and the spare code behaves the same
          if (hit) begin
            res.status = StFound;
            res.slot = 3'(hit_way);
          end else begin
            res.status = StNotFound;
          end
        end
      endcase
    end
    key_hash = HashSeed;
    key_len = 0;
    outcomes_due.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      key_hash = HashSeed;
      key_len = 0;
      foreach (table_len[i]) table_len[i] = 0;
      outcomes_due.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      // results first: a result accepted now always belongs to an older key
      if (out_valid_i && !out_stall_i) begin
        if (outcomes_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: status %0d bucket %0d slot %0d",
                                    status_i, bucket_i, slot_i));
        end else begin
          want = outcomes_due.pop_front();
          check_field("status", status_i, want.status);
          check_field("bucket", bucket_i, want.bucket);
          check_field("slot", slot_i, want.slot);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        absorb_byte(mode_i, key_byte_i, last_i);
      end
      fail_count_o <= mismatches;
      pending_o <= outcomes_due.size();
    end
  end

endmodule

@@ tb/string_key_hash_set_test.sv @@
// string_key_hash_set_test: clock, reset and key stimulus for string_key_hash_set,
// with random idling on both channels; the checker does the comparing.
// Depends on skhs_pkg, string_key_hash_set and string_key_hash_set_checker.
module string_key_hash_set_test;
  timeunit 1ns;
  timeprecision 1ps;
  import skhs_pkg::*;

  localparam logic [1:0] ModeFind  = 2'd1;
  localparam logic [1:0] ModeSpare = 2'd3;

  localparam int PoolSize   = 40;
  localparam int MaxKeyBuf  = 20;
  localparam int ByteTarget = 700;
  localparam int HoldCycles = 400;
  localparam int DrainWait  = 150;
  localparam int CycleLimit = 400000;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] mode_i;
  logic [7:0] key_byte_i;
  logic       last_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [2:0] status_o;
  logic [5:0] bucket_o;
  logic [2:0] slot_o;

  int fail_count;
  int pending_results;
  int cycle_count;
  int bytes_sent;
  bit quiet;
  bit hold_req;

  logic [7:0] key_buf[MaxKeyBuf];
  logic [7:0] pool_bytes[PoolSize][MaxKeyBuf];
  int         pool_len[PoolSize];

  string_key_hash_set i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .key_byte_i  (key_byte_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .bucket_o    (bucket_o),
    .slot_o      (slot_o)
  );

  string_key_hash_set_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .mode_i       (mode_i),
    .key_byte_i   (key_byte_i),
    .last_i       (last_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_i     (status_o),
    .bucket_i     (bucket_o),
    .slot_i       (slot_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        for (n = 0; n < HoldCycles; n++) begin
          out_stall_i <= 1'b1;
          @(posedge clk_i);
        end
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < 7);
      end
    end
  end

  task automatic push_byte(input logic [1:0] mode, input logic [7:0] kb, input logic kl);
    while (!quiet && $urandom_range(99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    key_byte_i <= kb;
    last_i <= kl;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
  endtask

  // sends key_buf[0 .. len-1]; mode only counts on the final byte
  task automatic send_key(input logic [1:0] mode, input int len);
    int i;
    for (i = 0; i < len; i++) begin
      if (i == len - 1) push_byte(mode, key_buf[i], 1'b1);
      else push_byte(2'($urandom_range(3)), key_buf[i], 1'b0);
    end
  endtask

  task automatic send_filled(input logic [1:0] mode, input int len, input logic [7:0] kb);
    int i;
    for (i = 0; i < len; i++) key_buf[i] = kb;
    send_key(mode, len);
  endtask

  function automatic int random_len();
    int r;
    r = $urandom_range(99);
    if (r < 65) return $urandom_range(4, 1);
    if (r < 90) return $urandom_range(16, 5);
    return $urandom_range(MaxKeyBuf - 1, 17);
  endfunction

  function automatic logic [1:0] random_mode();
    int r;
    r = $urandom_range(99);
    if (r < 40) return ModeInsert;
    if (r < 70) return ModeFind;
    if (r < 95) return ModeRemove;
    return ModeSpare;
  endfunction

  initial begin
    int k;
    int p;
    int i;
    int len;

    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = '0;
    key_byte_i = '0;
    last_i = 1'b0;
    out_stall_i = 1'b0;
    cycle_count = 0;
    bytes_sent = 0;
    quiet = 1'b0;
    hold_req = 1'b0;

    for (p = 0; p < PoolSize; p++) begin
      pool_len[p] = random_len();
      for (i = 0; i < MaxKeyBuf; i++) pool_bytes[p][i] = 8'($urandom_range(255));
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-byte keys 0x01 and 0x41 land in the same bucket
    send_filled(ModeInsert, 1, 8'h01);
    send_filled(ModeInsert, 1, 8'h01);
    send_filled(ModeInsert, 1, 8'h41);
    send_filled(ModeFind, 1, 8'h01);
    send_filled(ModeSpare, 1, 8'h01);
    send_filled(ModeRemove, 1, 8'h01);
    send_filled(ModeRemove, 1, 8'h01);
    send_filled(ModeFind, 1, 8'h41);
    send_filled(ModeInsert, 16, 8'hff);
    send_filled(ModeInsert, 17, 8'h00);

    k = 0;
    while (bytes_sent < ByteTarget) begin
      quiet = (k >= 20 && k < 35);
      if (k == 50) hold_req = 1'b1;
      if ($urandom_range(99) < 15) begin
        len = random_len();
        for (i = 0; i < len; i++) key_buf[i] = 8'($urandom_range(255));
      end else begin
        p = $urandom_range(PoolSize - 1);
        len = pool_len[p];
        for (i = 0; i < len; i++) key_buf[i] = pool_bytes[p][i];
      end
      send_key(random_mode(), len);
      k++;
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (fail_count == 0 && pending_results == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ string_key_hash_set.f @@
design/skhs_pkg.sv
design/skhs_ram.sv
design/skhs_hash.sv
design/string_key_hash_set.sv
tb/string_key_hash_set_checker.sv
tb/string_key_hash_set_test.sv
